FILE: hw/rtl/ppbp_pkg.sv
// Package for the pixel to parallel bus packer.
// Holds the bus format codes, field widths and the item types.
// No dependencies.
package ppbp_pkg;

  localparam int unsigned PixelWidth = 24;
  localparam int unsigned WordWidth  = 24;
  localparam int unsigned MaxWords   = 3;

  typedef logic [2:0]            bus_fmt_t;
  typedef logic [PixelWidth-1:0] pixel_t;
  typedef logic [WordWidth-1:0]  word_t;
  typedef logic [1:0]            word_cnt_t;

  localparam bus_fmt_t FMT_8BIT      = 3'd0;
  localparam bus_fmt_t FMT_9BIT      = 3'd1;
  localparam bus_fmt_t FMT_12BIT     = 3'd2;
  localparam bus_fmt_t FMT_16_PACKED = 3'd3;
  localparam bus_fmt_t FMT_16_565    = 3'd4;
  localparam bus_fmt_t FMT_18BIT     = 3'd5;
  localparam bus_fmt_t FMT_24BIT     = 3'd6;
  localparam bus_fmt_t FMT_RESERVED  = 3'd7;

  localparam bus_fmt_t BUS_FORMAT_RESET = FMT_8BIT;

  // Words produced by one pixel, waiting to go out.
  typedef struct packed {
    word_t [MaxWords-1:0] words;
    word_cnt_t            count;
  } word_set_t;

endpackage

FILE: hw/rtl/ppbp_if.sv
// Channel interfaces for the pixel to parallel bus packer.
// Depends on ppbp_pkg.
interface ppbp_pixel_if;
  import ppbp_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_color;
  logic   end_of_run;

  modport source (output valid, output pixel_color, output end_of_run, input ready);
  modport sink   (input valid, input pixel_color, input end_of_run, output ready);
endinterface

interface ppbp_word_if;
  import ppbp_pkg::*;
  logic  valid;
  logic  ready;
  word_t bus_word;
  logic  last_word;

  modport source (output valid, output bus_word, output last_word, input ready);
  modport sink   (input valid, input bus_word, input last_word, output ready);
endinterface

FILE: hw/rtl/pixel_to_parallel_bus_packer_unit.sv
// Pixel to parallel bus packer, top level.
// Depends on ppbp_pkg and the channel interfaces in ppbp_if.sv.
//
// Usage:
//   pixel_in carries one 24-bit pixel per transaction plus end_of_run.
//   bus_out carries one bus word per transaction; last_word marks the final
//   word caused by a pixel. bus_format is written through cfg_wr_en and
//   cfg_data while the block is idle and applies from the next pixel.
//   Each accepted pixel is turned into its one to three words in the same
//   cycle and held in a word buffer; words then move one per cycle into the
//   output register while it is empty or its word is taken. The first word
//   passes through the word buffer and then the output register to bus_out.
//   Throughput is one bus word per cycle while the receiver takes every word;
//   the single output register is the limit.
//   A new pixel is accepted in the cycle the last buffered word leaves, so
//   pixels flow back to back with no bubbles.
//   Reset clears the format to 8-bit, the pending packed byte and all
//   valid flags. When the receiver stalls, the output register holds its
//   word and the buffer fills; pixel_in.ready then drops.
module pixel_to_parallel_bus_packer_unit (
  input  logic                  clk,
  input  logic                  rst,
  ppbp_pixel_if.sink            pixel_in,
  ppbp_word_if.source           bus_out,
  input  logic                  cfg_wr_en,
  input  ppbp_pkg::bus_fmt_t    cfg_data
);
  import ppbp_pkg::*;

  bus_fmt_t  bus_format;
  logic      pending_valid;
  logic [7:0] pending_byte;

  word_set_t held;
  logic      held_valid;
  word_cnt_t held_idx;

  logic      out_valid;
  word_t     out_word;
  logic      out_last;

  word_set_t  item_next;
  logic       pending_valid_next;
  logic [7:0] pending_byte_next;
  logic       accept;
  logic       move;
  logic       move_last;
  pixel_t     c;

  assign c         = pixel_in.pixel_color;
  assign move      = held_valid && (!out_valid || bus_out.ready);
  assign move_last = move && (held_idx == held.count - 2'd1);
  assign pixel_in.ready = !held_valid || move_last;
  assign accept    = pixel_in.valid && pixel_in.ready;

  always_comb begin
    item_next          = '0;
    pending_valid_next = pending_valid;
    pending_byte_next  = pending_byte;
    unique case (bus_format)
      FMT_8BIT: begin
        item_next.words[0] = {16'h0, c[23:16]};
        item_next.words[1] = {16'h0, c[15:8]};
        item_next.words[2] = {16'h0, c[7:0]};
        item_next.count    = 2'd3;
      end
      FMT_9BIT: begin
        item_next.words[0] = {15'h0, c[17:9]};
        item_next.words[1] = {15'h0, c[8:0]};
        item_next.count    = 2'd2;
      end
      FMT_12BIT: begin
        item_next.words[0] = {12'h0, c[23:12]};
        item_next.words[1] = {12'h0, c[11:0]};
        item_next.count    = 2'd2;
      end
      FMT_16_PACKED: begin
        if (pending_valid) begin
          item_next.words[0] = {8'h0, pending_byte, c[23:16]};
          item_next.words[1] = {8'h0, c[15:0]};
          item_next.count    = 2'd2;
          pending_valid_next = 1'b0;
        end else if (pixel_in.end_of_run) begin
          // odd pixel at end of run: flush blue straight away
          item_next.words[0] = {8'h0, c[23:8]};
          item_next.words[1] = {8'h0, c[7:0], 8'h0};
          item_next.count    = 2'd2;
          pending_byte_next  = c[7:0];
          pending_valid_next = 1'b0;
        end else begin
          item_next.words[0] = {8'h0, c[23:8]};
          item_next.count    = 2'd1;
          pending_byte_next  = c[7:0];
          pending_valid_next = 1'b1;
        end
      end
      FMT_16_565: begin
        item_next.words[0] = {8'h0, c[15:0]};
        item_next.count    = 2'd1;
      end
      FMT_18BIT: begin
        item_next.words[0] = {6'h0, c[17:0]};
        item_next.count    = 2'd1;
      end
      default: begin
        // 24-bit bus; the reserved code behaves the same
        item_next.words[0] = c;
        item_next.count    = 2'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_format    <= BUS_FORMAT_RESET;
      pending_valid <= 1'b0;
      pending_byte  <= '0;
      held_valid    <= 1'b0;
      held_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bus_format <= cfg_data;
      end
      if (accept) begin
        pending_valid <= pending_valid_next;
        pending_byte  <= pending_byte_next;
        held_valid    <= 1'b1;
        held_idx      <= '0;
      end else if (move_last) begin
        held_valid <= 1'b0;
      end else if (move) begin
        held_idx <= held_idx + 2'd1;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (bus_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item_next;
    end
    if (move) begin
      out_word <= held.words[held_idx];
      out_last <= (held_idx == held.count - 2'd1);
    end
  end

  assign bus_out.valid     = out_valid;
  assign bus_out.bus_word  = out_word;
  assign bus_out.last_word = out_last;

  // buffered word index stays inside the buffered word count
  assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (held_idx < held.count))
    else $error("word buffer index beyond count");

  // a pixel is only taken when the buffer is empty or draining its last word
  assert property (@(posedge clk) disable iff (rst)
    accept |-> (!held_valid || move_last))
    else $error("pixel accepted over undelivered words");

  // pending byte flag changes only on a packed-format pixel
  assert property (@(posedge clk) disable iff (rst)
    (pending_valid != $past(pending_valid)) |->
      ($past(accept) && $past(bus_format) == FMT_16_PACKED && !$past(rst)))
    else $error("pending byte flag changed outside packed format");

endmodule

FILE: tb/pixel_to_parallel_bus_packer_unit_test.sv
// Self-checking testbench for pixel_to_parallel_bus_packer_unit.
// Directed rows, random runs over all bus formats; random stalls on both channels bar phase 2.
// Depends on ppbp_pkg and the channel interfaces in ppbp_if.sv.
module pixel_to_parallel_bus_packer_unit_test;
  import ppbp_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int RandomPixelsPerPhase = 150;
  localparam int NumDirected = 23;

  typedef struct {
    bus_fmt_t fmt;
    pixel_t   color;
    logic     eor;
    int       n_typed;   // 0: words come from the predictor
    word_t    w0;
    word_t    w1;
    word_t    w2;
  } pixel_row_t;

  typedef struct {
    word_t word;
    logic  last;
  } bus_word_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_wr_en;
  bus_fmt_t cfg_data;

  ppbp_pixel_if pixel_in ();
  ppbp_word_if  bus_out ();

  pixel_to_parallel_bus_packer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .bus_out   (bus_out),
    .cfg_wr_en (cfg_wr_en),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state
  bus_fmt_t  fmt_now;
  logic      held_valid;
  logic [7:0] held_byte;

  bus_word_t bus_words_due[$];
  int        mismatches = 0;
  int        pixels_sent = 0;
  int        words_seen = 0;
  int        formats_set = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  pixel_row_t directed_rows [NumDirected] = '{
    '{FMT_8BIT,      24'hFFFFFF, 1'b0, 3, 24'h0000FF, 24'h0000FF, 24'h0000FF},
    '{FMT_8BIT,      24'h000000, 1'b0, 3, 24'h000000, 24'h000000, 24'h000000},
    '{FMT_8BIT,      24'h123456, 1'b0, 3, 24'h000012, 24'h000034, 24'h000056},
    '{FMT_9BIT,      24'hFFFFFF, 1'b0, 2, 24'h0001FF, 24'h0001FF, 24'h0},
    '{FMT_9BIT,      24'h0A5A5A, 1'b1, 0, 24'h0, 24'h0, 24'h0},
    '{FMT_12BIT,     24'hFFFFFF, 1'b0, 2, 24'h000FFF, 24'h000FFF, 24'h0},
    '{FMT_12BIT,     24'h123456, 1'b0, 2, 24'h000123, 24'h000456, 24'h0},
    '{FMT_16_PACKED, 24'h112233, 1'b0, 1, 24'h001122, 24'h0, 24'h0},
    '{FMT_16_PACKED, 24'h445566, 1'b0, 2, 24'h003344, 24'h005566, 24'h0},
    '{FMT_16_PACKED, 24'hAABBCC, 1'b1, 2, 24'h00AABB, 24'h00CC00, 24'h0},
    '{FMT_16_PACKED, 24'hFFFFFF, 1'b1, 2, 24'h00FFFF, 24'h00FF00, 24'h0},
    '{FMT_16_PACKED, 24'h010203, 1'b0, 1, 24'h000102, 24'h0, 24'h0},
    '{FMT_16_PACKED, 24'h040506, 1'b1, 2, 24'h000304, 24'h000506, 24'h0},
    // leave a byte held across the following format changes
    '{FMT_16_PACKED, 24'h778899, 1'b0, 1, 24'h007788, 24'h0, 24'h0},
    '{FMT_16_565,    24'hFFFFFF, 1'b1, 1, 24'h00FFFF, 24'h0, 24'h0},
    '{FMT_18BIT,     24'hFFFFFF, 1'b0, 1, 24'h03FFFF, 24'h0, 24'h0},
    '{FMT_24BIT,     24'hFFFFFF, 1'b0, 1, 24'hFFFFFF, 24'h0, 24'h0},
    '{FMT_24BIT,     24'h000000, 1'b1, 1, 24'h000000, 24'h0, 24'h0},
    '{FMT_RESERVED,  24'hABCDEF, 1'b0, 1, 24'hABCDEF, 24'h0, 24'h0},
    '{FMT_8BIT,      24'hA5A5A5, 1'b1, 3, 24'h0000A5, 24'h0000A5, 24'h0000A5},
    '{FMT_16_PACKED, 24'h000000, 1'b0, 2, 24'h009900, 24'h000000, 24'h0},
    '{FMT_16_PACKED, 24'h5A5A5A, 1'b0, 1, 24'h005A5A, 24'h0, 24'h0},
    '{FMT_9BIT,      24'h800100, 1'b0, 0, 24'h0, 24'h0, 24'h0}
  };

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic word_t fmt_width_mask(input bus_fmt_t fmt);
    case (fmt)
      FMT_8BIT:      return 24'h0000FF;
      FMT_9BIT:      return 24'h0001FF;
      FMT_12BIT:     return 24'h000FFF;
      FMT_16_PACKED: return 24'h00FFFF;
      FMT_16_565:    return 24'h00FFFF;
      FMT_18BIT:     return 24'h03FFFF;
      default:       return 24'hFFFFFF;
    endcase
  endfunction

  // Words one pixel produces under the current format; updates the held byte.
  function automatic int pack_pixel(input pixel_t color, input logic eor, output word_t w [3]);
    int n;
    n = 0;
    case (fmt_now)
      FMT_8BIT: begin
        w[0] = color >> 16;
        w[1] = color >> 8;
        w[2] = color;
        n = 3;
      end
      FMT_9BIT: begin
        w[0] = color >> 9;
        w[1] = color;
        n = 2;
      end
      FMT_12BIT: begin
        w[0] = color >> 12;
        w[1] = color;
        n = 2;
      end
      FMT_16_PACKED: begin
        if (held_valid) begin
          w[0] = {8'h00, held_byte, color[23:16]};
          w[1] = color;
          n = 2;
          held_valid = 1'b0;
        end else begin
          w[0] = color >> 8;
          n = 1;
          held_byte = color[7:0];
          held_valid = 1'b1;
        end
        if (eor && held_valid) begin
          w[n] = {8'h00, held_byte, 8'h00};
          n++;
          held_valid = 1'b0;
        end
      end
      default: begin
        w[0] = color;
        n = 1;
      end
    endcase
    for (int i = 0; i < n; i++) w[i] = w[i] & fmt_width_mask(fmt_now);
    return n;
  endfunction

  task automatic drain_results();
    pixel_in.valid <= 1'b0;
    do @(posedge clk); while (bus_words_due.size() != 0);
  endtask

  task automatic set_format(input bus_fmt_t fmt);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_data  <= fmt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fmt_now = fmt;
    formats_set++;
  endtask

  task automatic send_pixel(input pixel_row_t r);
    word_t w [3];
    word_t t [3];
    int    n;
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_in.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_in.valid       <= 1'b1;
    pixel_in.pixel_color <= r.color;
    pixel_in.end_of_run  <= r.eor;
    do @(posedge clk); while (!pixel_in.ready);
    pixels_sent++;
    n = pack_pixel(r.color, r.eor, w);
    if (r.n_typed != 0) begin
      t[0] = r.w0;
      t[1] = r.w1;
      t[2] = r.w2;
      n = r.n_typed;
      w = t;
    end
    for (int i = 0; i < n; i++) bus_words_due.push_back('{word: w[i], last: (i == n - 1)});
  endtask

  // Receiver: random stalls, checks every word against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      bus_out.ready <= 1'b0;
    end else begin
      bus_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (bus_out.valid && bus_out.ready) begin
        words_seen++;
        if (bus_words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected bus word %h", bus_out.bus_word));
        end else begin
          bus_word_t due;
          due = bus_words_due.pop_front();
          if (bus_out.bus_word !== due.word)
            report_mismatch($sformatf("bus_word %h, expected %h", bus_out.bus_word, due.word));
          if (bus_out.last_word !== due.last)
            report_mismatch($sformatf("last_word %b, expected %b on word %h",
                                      bus_out.last_word, due.last, due.word));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    pixel_row_t r;
    int         burst;
    int         sent;
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_data             <= FMT_8BIT;
    pixel_in.valid       <= 1'b0;
    pixel_in.pixel_color <= '0;
    pixel_in.end_of_run  <= 1'b0;
    fmt_now    = BUS_FORMAT_RESET;
    held_valid = 1'b0;
    held_byte  = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 58;
    // First rows run on the reset format before any write
    for (int i = 0; i < NumDirected; i++) begin
      if (directed_rows[i].fmt != fmt_now || i == 3) set_format(directed_rows[i].fmt);
      send_pixel(directed_rows[i]);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 25; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < RandomPixelsPerPhase) begin
        // packed runs get extra weight, they carry the only state
        if ($urandom_range(2) == 0) set_format(FMT_16_PACKED);
        else set_format(bus_fmt_t'($urandom_range(7)));
        burst = $urandom_range(4, 30);
        for (int k = 0; k < burst; k++) begin
          r.fmt     = fmt_now;
          r.n_typed = 0;
          case ($urandom_range(9))
            0: r.color = 24'h000000;
            1: r.color = 24'hFFFFFF;
            default: r.color = pixel_t'($urandom);
          endcase
          if (fmt_now == FMT_16_PACKED) r.eor = ($urandom_range(7) == 0);
          else r.eor = 1'($urandom_range(1));
          if ($urandom_range(24) == 0) drain_results();
          send_pixel(r);
          sent++;
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d pixels, checked %0d bus words over %0d format writes,",
             pixels_sent, words_seen, formats_set);
    $display("all eight format codes, packed runs with flushes and held bytes.");
    if (mismatches == 0 && bus_words_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
